// ===== design/day_night_light_controller_macros.svh =====
// Assertion macros for the day/night light controller checker.
// No dependencies; included by the files that carry assertions.
`ifndef DAY_NIGHT_LIGHT_CONTROLLER_MACROS_SVH
`define DAY_NIGHT_LIGHT_CONTROLLER_MACROS_SVH

// Checked outside reset.
`define DNLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define DNLC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/dnlc_pkg.sv =====
// Shared types and constants for the day/night light controller.
// No dependencies.
package dnlc_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int THRESH_W        = 10;
  localparam int PERIOD_W        = 16;
  localparam int ONTIME_W        = 16;
  localparam int CONFIRM_W       = 2;
  localparam int COLOR_W         = 24;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DARK_THRESH   = 3'd0;
  localparam logic [2:0] REG_BRIGHT_THRESH = 3'd1;
  localparam logic [2:0] REG_EVAL_PERIOD   = 3'd2;
  localparam logic [2:0] REG_ON_TIME_LIMIT = 3'd3;
  localparam logic [2:0] REG_CONFIRM_COUNT = 3'd4;
  localparam logic [2:0] REG_ON_COLOR      = 3'd5;
  localparam logic [2:0] REG_OFF_COLOR     = 3'd6;

  // Reset values: thresholds are 2.9 V and 2.0 V at 5 V / 1024 counts
  localparam logic [THRESH_W-1:0]  DARK_THRESH_RST   = 10'd593;
  localparam logic [THRESH_W-1:0]  BRIGHT_THRESH_RST = 10'd410;
  localparam logic [PERIOD_W-1:0]  EVAL_PERIOD_RST   = 16'd3600;
  localparam logic [ONTIME_W-1:0]  ON_TIME_LIMIT_RST = 16'd300;
  localparam logic [CONFIRM_W-1:0] CONFIRM_COUNT_RST = 2'd2;
  localparam logic [COLOR_W-1:0]   ON_COLOR_RST      = 24'h666666;
  localparam logic [COLOR_W-1:0]   OFF_COLOR_RST     = 24'h000000;

  typedef enum logic [1:0] {
    PH_INIT      = 2'd0,
    PH_DAY       = 2'd1,
    PH_NIGHT_ON  = 2'd2,
    PH_NIGHT_OFF = 2'd3
  } phase_t;

  typedef struct packed {
    logic [THRESH_W-1:0]  dark_threshold;
    logic [THRESH_W-1:0]  bright_threshold;
    logic [PERIOD_W-1:0]  evaluation_period;
    logic [ONTIME_W-1:0]  on_time_limit;
    logic [CONFIRM_W-1:0] confirm_count;
    logic [COLOR_W-1:0]   on_color;
    logic [COLOR_W-1:0]   off_color;
  } cfg_t;

  typedef struct packed {
    logic               strip_write;
    logic [COLOR_W-1:0] strip_color;
    phase_t             mode;
  } result_t;

endpackage

// ===== design/dnlc_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on dnlc_pkg.
module dnlc_cfg_regs
  import dnlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DARK_THRESH:   cfg_nxt.dark_threshold    = pwdata[THRESH_W-1:0];
        REG_BRIGHT_THRESH: cfg_nxt.bright_threshold  = pwdata[THRESH_W-1:0];
        REG_EVAL_PERIOD:   cfg_nxt.evaluation_period = pwdata[PERIOD_W-1:0];
        REG_ON_TIME_LIMIT: cfg_nxt.on_time_limit     = pwdata[ONTIME_W-1:0];
        REG_CONFIRM_COUNT: cfg_nxt.confirm_count     = pwdata[CONFIRM_W-1:0];
        REG_ON_COLOR:      cfg_nxt.on_color          = pwdata[COLOR_W-1:0];
        REG_OFF_COLOR:     cfg_nxt.off_color         = pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DARK_THRESH:   prdata = DATA_W'(cfg_r.dark_threshold);
      REG_BRIGHT_THRESH: prdata = DATA_W'(cfg_r.bright_threshold);
      REG_EVAL_PERIOD:   prdata = DATA_W'(cfg_r.evaluation_period);
      REG_ON_TIME_LIMIT: prdata = DATA_W'(cfg_r.on_time_limit);
      REG_CONFIRM_COUNT: prdata = DATA_W'(cfg_r.confirm_count);
      REG_ON_COLOR:      prdata = DATA_W'(cfg_r.on_color);
      REG_OFF_COLOR:     prdata = DATA_W'(cfg_r.off_color);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_threshold    <= DARK_THRESH_RST;
      cfg_r.bright_threshold  <= BRIGHT_THRESH_RST;
      cfg_r.evaluation_period <= EVAL_PERIOD_RST;
      cfg_r.on_time_limit     <= ON_TIME_LIMIT_RST;
      cfg_r.confirm_count     <= CONFIRM_COUNT_RST;
      cfg_r.on_color          <= ON_COLOR_RST;
      cfg_r.off_color         <= OFF_COLOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/dnlc_core.sv =====
// Controller state (prescaler, phase, confirm run, on-time count) and the
// per-tick evaluation logic. Depends on dnlc_pkg.
module dnlc_core
  import dnlc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  cfg_t                   cfg,
  output result_t                result
);

  localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam logic [CONFIRM_W-1:0] RUN_MAX = '1;
  localparam logic [ONTIME_W-1:0]  ON_MAX  = '1;

  logic [PERIOD_W-1:0]  tick_r,   tick_nxt;
  phase_t               phase_r,  phase_nxt;
  logic [CONFIRM_W-1:0] run_r,    run_nxt;
  logic [ONTIME_W-1:0]  on_cnt_r, on_cnt_nxt;

  logic [CMP_W-1:0]     sample_x;
  logic                 evaluate;
  logic                 dark;
  logic                 bright;
  logic                 hit;
  logic [CONFIRM_W-1:0] need;
  logic [CONFIRM_W-1:0] run_hit;
  logic                 confirmed;
  logic [ONTIME_W-1:0]  on_inc;

  assign sample_x = CMP_W'(sample);
  assign evaluate = !(tick_r < cfg.evaluation_period);
  assign dark     = sample_x > CMP_W'(cfg.dark_threshold);
  assign bright   = sample_x < CMP_W'(cfg.bright_threshold);
  // day looks for dark samples, both night phases for bright ones
  assign hit      = (phase_r == PH_DAY) ? dark : bright;
  // a zero confirm count behaves as one
  assign need     = (cfg.confirm_count == '0) ? CONFIRM_W'(1) : cfg.confirm_count;
  assign run_hit  = !hit ? '0 : (run_r == RUN_MAX) ? run_r : run_r + CONFIRM_W'(1);
  assign confirmed = run_hit >= need;
  assign on_inc   = (on_cnt_r == ON_MAX) ? on_cnt_r : on_cnt_r + ONTIME_W'(1);

  always_comb begin
    tick_nxt           = tick_r + PERIOD_W'(1);
    phase_nxt          = phase_r;
    run_nxt            = run_r;
    on_cnt_nxt         = on_cnt_r;
    result.strip_write = 1'b0;
    result.strip_color = '0;
    if (evaluate) begin
      tick_nxt = '0;
      case (phase_r)
        PH_INIT: begin
          result.strip_write = 1'b1;
          if (dark) begin
            result.strip_color = cfg.on_color;
            phase_nxt          = PH_NIGHT_ON;
          end else begin
            result.strip_color = cfg.off_color;
            phase_nxt          = PH_DAY;
          end
        end
        PH_DAY: begin
          run_nxt = run_hit;
          if (confirmed) begin
            result.strip_write = 1'b1;
            result.strip_color = cfg.on_color;
            run_nxt            = '0;
            on_cnt_nxt         = '0;
            phase_nxt          = PH_NIGHT_ON;
          end
        end
        PH_NIGHT_ON: begin
          run_nxt    = run_hit;
          on_cnt_nxt = on_inc;
          // time-out wins over a confirmed return to day
          if (on_inc > cfg.on_time_limit) begin
            result.strip_write = 1'b1;
            result.strip_color = cfg.off_color;
            run_nxt            = '0;
            phase_nxt          = PH_NIGHT_OFF;
          end else if (confirmed) begin
            result.strip_write = 1'b1;
            result.strip_color = cfg.off_color;
            run_nxt            = '0;
            phase_nxt          = PH_DAY;
          end
        end
        PH_NIGHT_OFF: begin
          run_nxt = run_hit;
          if (confirmed) begin
            result.strip_write = 1'b1;
            result.strip_color = cfg.off_color;
            run_nxt            = '0;
            phase_nxt          = PH_DAY;
          end
        end
        default: ;
      endcase
    end
    result.mode = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '1;
      phase_r  <= PH_INIT;
      run_r    <= '0;
      on_cnt_r <= '0;
    end else if (step) begin
      tick_r   <= tick_nxt;
      phase_r  <= phase_nxt;
      run_r    <= run_nxt;
      on_cnt_r <= on_cnt_nxt;
    end
  end

endmodule

// ===== design/day_night_light_controller.sv =====
// Day/night light controller, top level: sample input register, controller
// core, result register and configuration registers. Depends on dnlc_pkg,
// dnlc_cfg_regs and dnlc_core.
//
// Usage:
//   in_*   : one transaction per timer tick; in_tdata carries the light sample.
//   out_*  : one result transaction per input tick, in order. out_tuser is the
//            strip write strobe; out_tdata holds the fill colour and the mode.
//   cfg    : APB-style registers at byte address 4*index; pready is tied high.
//            Write registers only while no ticks are in flight.
// Path: a tick accepted into the sample register passes through the core, and
//   its result is shown from the result register.
// Throughput: one tick per cycle unless out_tready stalls; the state update is a
//   single pass of compare/increment logic between sample and result registers.
// Reset: synchronous; registers go to their defaults, the prescaler is set so
//   the first tick evaluates, the phase returns to init and both pipeline
//   stages empty.
// Stall: when out_tready is low the result register holds, the sample register
//   fills, and in_tready drops until the result is taken.
module day_night_light_controller
  import dnlc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] light_sample, rest zero padding
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,
  // out_tdata: [23:0] strip_color, [25:24] mode, [31:26] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,
  // out_tuser: [0] strip_write
  output logic                              out_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ADDR_W-1:0]                 paddr,
  input  logic [DATA_W-1:0]                 pwdata,
  output logic [DATA_W-1:0]                 prdata,
  output logic                              pready
);

  cfg_t                   cfg;
  result_t                result;
  logic                   s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_res_r;
  logic                   advance;

  assign pready = 1'b1;

  dnlc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  dnlc_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .sample (s1_sample_r),
    .cfg    (cfg),
    .result (result)
  );

  // tick moves from the sample register into the result register
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  assign s1_valid_nxt  = (in_tvalid && in_tready) || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_sample_r <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (advance) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.strip_write;
  assign out_tdata  = {6'd0, out_res_r.mode, out_res_r.strip_color};

endmodule

// ===== design/dnlc_checker.sv =====
// Port-level checker for the day/night light controller, bound to the top.
// Depends on dnlc_pkg and day_night_light_controller_macros.svh.
`include "day_night_light_controller_macros.svh"

module dnlc_checker
  import dnlc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  `DNLC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  // every strip write leaves init behind
  `DNLC_ASSERT(a_write_mode, out_tvalid && out_tuser |-> out_tdata[25:24] != PH_INIT, "write in init")
  `DNLC_ASSERT(a_color_idle, out_tvalid && !out_tuser |-> out_tdata[23:0] == 24'd0, "color without write")
  `DNLC_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind day_night_light_controller dnlc_checker u_dnlc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
